// File: src/weighted_histogram_binner_defines.svh
// Assertion macros for the weighted histogram binner.
`ifndef WEIGHTED_HISTOGRAM_BINNER_DEFINES_SVH
`define WEIGHTED_HISTOGRAM_BINNER_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define WHB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, disabled during reset.
`define WHB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define WHB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define WHB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: src/whb_pkg.sv
// Shared types, codes and helpers of the weighted histogram binner.
`timescale 1ns / 1ps

package whb_pkg;

	localparam int MAX_BINS = 1024;
	localparam int IDX_W    = $clog2(MAX_BINS);
	localparam int NB_W     = IDX_W + 1;
	localparam int CNT_W    = 32;
	localparam int SMP_W    = 32;
	localparam int BS_W     = 31;
	localparam int WGT_W    = 16;
	localparam int DIV_STEPS = SMP_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Operation codes
	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// Result status codes
	localparam logic [2:0] ST_UNDER   = 3'd0;
	localparam logic [2:0] ST_IN_BIN  = 3'd1;
	localparam logic [2:0] ST_OVER    = 3'd2;
	localparam logic [2:0] ST_CLEARED = 3'd3;
	localparam logic [2:0] ST_BEYOND  = 3'd4;

	// Configuration register indexes
	localparam logic [1:0] REG_LOWER    = 2'd0;
	localparam logic [1:0] REG_BIN_SIZE = 2'd1;
	localparam logic [1:0] REG_NUM_BINS = 2'd2;

	typedef struct packed {
		logic             start;
		logic [SMP_W-1:0] dividend;
		logic [BS_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [SMP_W-1:0] quot;
		logic             rem_nz;
	} div_rsp_t;

	// Saturating count update
	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
			input logic [WGT_W-1:0] w);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {{(CNT_W + 1 - WGT_W){1'b0}}, w};
		return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
	endfunction

endpackage

// File: src/whb_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module whb_div import whb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [SMP_W-1:0]     quot_q;
	logic [BS_W-1:0]      rem_q;
	logic [BS_W-1:0]      dvs_q;
	logic [SMP_W:0]       trial;
	logic                 borrow;

	// Trial subtract of the divisor from the shifted partial remainder
	assign trial  = {1'b0, rem_q, quot_q[SMP_W-1]} - {2'b00, dvs_q};
	assign borrow = trial[SMP_W];

	// Sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !req.start && busy_q && (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Shift in one quotient bit per step
	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= req.dividend;
			rem_q  <= '0;
			dvs_q  <= req.divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[SMP_W-2:0], ~borrow};
			if (borrow) begin
				rem_q <= {rem_q[BS_W-2:0], quot_q[SMP_W-1]};
			end else begin
				rem_q <= trial[BS_W-1:0];
			end
		end
	end

	assign rsp.done   = done_q;
	assign rsp.quot   = quot_q;
	assign rsp.rem_nz = |rem_q;

endmodule

// File: src/whb_ram.sv
// Simple dual-port RAM with registered read data.
`timescale 1ns / 1ps

module whb_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/weighted_histogram_binner.sv
// Weighted histogram binner: 1024 saturating 32-bit bins plus outlier counts.
//
// Input channel (in_valid / in_stall) takes one request: op add with sample
// and weight, op clear, or op read with read_index. Each request except op
// code 3 yields one result on the output channel (out_valid / out_stall);
// op code 3 is taken and dropped. Configuration (lower_bound, bin width,
// bin count) is written through cfg_we / cfg_index / cfg_data; the user must
// do so only while idle, which the block does not enforce. Per request:
//   add in range: the restoring divider, one quotient bit per cycle, then one
//     RAM read and one write-back; add above range: the divider, no RAM access
//   add below range or read past the bins: no RAM access; read: one RAM read
//   op code 3: dropped; clear: one bin zeroed a cycle, all 1024 bins
// A result shows in the same cycle that the block turns idle and can take the next request.
// The block takes one request at a time; in_stall is high while it works.
// A result sits in an output register, so a stalled receiver holds only that
// register; a finished request waits for it before the next one is taken.
// After reset the bin RAM is zeroed, one entry a cycle, all 1024 entries, while
// in_stall stays high; configuration writes are taken during that time.
`timescale 1ns / 1ps
`include "weighted_histogram_binner_defines.svh"

module weighted_histogram_binner import whb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       op,
	input  logic [SMP_W-1:0] sample,
	input  logic [WGT_W-1:0] weight,
	input  logic [IDX_W-1:0] read_index,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [2:0]       status,
	output logic [IDX_W-1:0] bin_index,
	output logic [CNT_W-1:0] bin_count,
	output logic [CNT_W-1:0] underflow_total,
	output logic [CNT_W-1:0] overflow_total,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [SMP_W-1:0] cfg_data
);

	localparam logic [2:0] S_CLR   = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_DIV   = 3'd2;
	localparam logic [2:0] S_RADDR = 3'd3;
	localparam logic [2:0] S_RD    = 3'd4;
	localparam logic [2:0] S_RESP  = 3'd5;

	logic [2:0]       state_q;
	logic [IDX_W-1:0] clr_q;
	logic             clr_resp_q;
	logic             is_add_q;
	logic [WGT_W-1:0] weight_q;
	logic [IDX_W-1:0] idx_q;
	logic [2:0]       res_status_q;
	logic [CNT_W-1:0] res_cnt_q;
	logic [SMP_W-1:0] lower_q;
	logic [BS_W-1:0]  bsize_q;
	logic [NB_W-1:0]  nbins_q;
	logic [CNT_W-1:0] under_q;
	logic [CNT_W-1:0] over_q;
	logic             out_valid_q;
	logic [2:0]       out_status_q;
	logic [IDX_W-1:0] out_idx_q;
	logic [CNT_W-1:0] out_cnt_q;
	logic [CNT_W-1:0] out_under_q;
	logic [CNT_W-1:0] out_over_q;

	logic [NB_W-1:0]  nb;
	logic [BS_W-1:0]  eff_bs;
	logic [SMP_W:0]   diff;
	logic             below;
	logic             in_acc;
	logic             out_free;
	logic [SMP_W-1:0] nb_ext;
	logic             q_over;
	logic             q_last;
	logic [NB_W-1:0]  nb_m1;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [CNT_W-1:0] mem_wdata;
	logic             mem_re;
	logic [CNT_W-1:0] mem_rdata;
	logic [CNT_W-1:0] sat_new;
	div_req_t         div_req;
	div_rsp_t         div_rsp;

	// Effective bin count and width
	always_comb begin
		if (nbins_q == '0) begin
			nb = NB_W'(1);
		end else if (nbins_q > NB_W'(MAX_BINS)) begin
			nb = NB_W'(MAX_BINS);
		end else begin
			nb = nbins_q;
		end
	end
	assign eff_bs = (bsize_q == '0) ? BS_W'(1) : bsize_q;
	assign nb_m1  = nb - 1'b1;
	assign nb_ext = {{(SMP_W - NB_W){1'b0}}, nb};

	// Offset from the lower bound and the underflow test
	assign diff  = {sample[SMP_W-1], sample} - {lower_q[SMP_W-1], lower_q};
	assign below = diff[SMP_W];

	assign in_acc   = in_valid && (state_q == S_IDLE);
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// Overflow and last-bin tests on the quotient
	assign q_over = (div_rsp.quot > nb_ext) || ((div_rsp.quot == nb_ext) && div_rsp.rem_nz);
	assign q_last = (div_rsp.quot >= nb_ext);

	assign div_req.start    = in_acc && (op == OP_ADD) && !below;
	assign div_req.dividend = diff[SMP_W-1:0];
	assign div_req.divisor  = eff_bs;

	whb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Bin RAM port control
	assign sat_new   = sat_add(mem_rdata, weight_q);
	assign mem_re    = (state_q == S_RADDR);
	assign mem_we    = (state_q == S_CLR) || ((state_q == S_RD) && is_add_q);
	assign mem_waddr = (state_q == S_CLR) ? clr_q : idx_q;
	assign mem_wdata = (state_q == S_CLR) ? '0 : sat_new;

	whb_ram #(
		.DEPTH (MAX_BINS),
		.WIDTH (CNT_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (idx_q),
		.rdata (mem_rdata)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= '0;
			bsize_q <= BS_W'(1);
			nbins_q <= NB_W'(10);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LOWER:    lower_q <= cfg_data;
				REG_BIN_SIZE: bsize_q <= cfg_data[BS_W-1:0];
				REG_NUM_BINS: nbins_q <= cfg_data[NB_W-1:0];
				default:      ;
			endcase
		end
	end

	// Sequencer and outlier counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			clr_q      <= '0;
			clr_resp_q <= 1'b0;
			under_q    <= '0;
			over_q     <= '0;
		end else begin
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IDX_W'(MAX_BINS - 1)) begin
						state_q <= clr_resp_q ? S_RESP : S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						case (op)
							OP_ADD: begin
								if (below) begin
									under_q <= sat_add(under_q, weight);
									state_q <= S_RESP;
								end else begin
									state_q <= S_DIV;
								end
							end
							OP_CLEAR: begin
								under_q    <= '0;
								over_q     <= '0;
								clr_q      <= '0;
								clr_resp_q <= 1'b1;
								state_q    <= S_CLR;
							end
							OP_READ: begin
								if ({1'b0, read_index} < nb) begin
									state_q <= S_RADDR;
								end else begin
									state_q <= S_RESP;
								end
							end
							default: ;
						endcase
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						if (q_over) begin
							over_q  <= sat_add(over_q, weight_q);
							state_q <= S_RESP;
						end else begin
							state_q <= S_RADDR;
						end
					end
				end
				S_RADDR: state_q <= S_RD;
				S_RD:    state_q <= S_RESP;
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Request payload and pending result fields
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				weight_q  <= weight;
				is_add_q  <= (op == OP_ADD);
				res_cnt_q <= '0;
				if (op == OP_CLEAR) begin
					idx_q        <= '0;
					res_status_q <= ST_CLEARED;
				end else if (op == OP_READ) begin
					idx_q        <= read_index;
					res_status_q <= ({1'b0, read_index} < nb) ? ST_IN_BIN : ST_BEYOND;
				end else begin
					idx_q        <= '0;
					res_status_q <= ST_UNDER;
				end
			end
			S_DIV: begin
				if (div_rsp.done) begin
					if (q_over) begin
						res_status_q <= ST_OVER;
						idx_q        <= '0;
					end else begin
						res_status_q <= ST_IN_BIN;
						idx_q        <= q_last ? nb_m1[IDX_W-1:0] : div_rsp.quot[IDX_W-1:0];
					end
				end
			end
			S_RD: begin
				res_cnt_q <= is_add_q ? sat_new : mem_rdata;
			end
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_RESP) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_RESP) && out_free) begin
			out_status_q <= res_status_q;
			out_idx_q    <= idx_q;
			out_cnt_q    <= res_cnt_q;
			out_under_q  <= under_q;
			out_over_q   <= over_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = out_status_q;
	assign bin_index       = out_idx_q;
	assign bin_count       = out_cnt_q;
	assign underflow_total = out_under_q;
	assign overflow_total  = out_over_q;

	// Checks
	`WHB_ASSERT_IMP(a_div_done_in_div, clk, arst_n, div_rsp.done, state_q == S_DIV,
		"divider finished outside the divide state")
	`WHB_ASSERT_IMP(a_bin_write_in_range, clk, arst_n, mem_we && (state_q == S_RD),
		idx_q <= nb_m1[IDX_W-1:0], "bin update beyond the bins in use")
	`WHB_ASSERT_IMP(a_out_rise_from_resp, clk, arst_n, $rose(out_valid_q),
		$past(state_q) == S_RESP, "result shown without a finished request")
	`WHB_ASSERT_NXT(a_resp_loads_out, clk, arst_n, (state_q == S_RESP) && out_free,
		out_valid_q && (state_q == S_IDLE), "finished request not moved to the output")

endmodule
